>>> src/lcdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, constants and helpers for the character display nibble driver.
// ----------------------------------------------------------------------------
package lcdn_pkg;

	localparam int CFG_W   = 16;
	localparam int CNT_W   = 16;
	localparam int NUM_CFG = 7;
	localparam int ADDR_W  = 5;

	// register indexes
	typedef enum logic [2:0] {
		REG_POWER_UP  = 3'd0,
		REG_EN_HIGH   = 3'd1,
		REG_WAKE_GAP1 = 3'd2,
		REG_WAKE_GAP2 = 3'd3,
		REG_MODE_GAP  = 3'd4,
		REG_CMD_SETL  = 3'd5,
		REG_DATA_SETL = 3'd6
	} reg_idx_t;

	// input selector codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SEND = 2'd1;
	localparam logic [1:0] CMD_INIT = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POWER,
		PH_HI_STROBE,
		PH_HI_HOLD,
		PH_LO_STROBE,
		PH_SETTLE,
		PH_NIB_STROBE,
		PH_NIB_GAP
	} phase_t;

	// init sequence steps
	localparam logic [3:0] STEP_NONE      = 4'd0;
	localparam logic [3:0] STEP_WAKE1     = 4'd1;
	localparam logic [3:0] STEP_WAKE2     = 4'd2;
	localparam logic [3:0] STEP_MODE_NIB  = 4'd4;
	localparam logic [3:0] STEP_BYTE_FIRST = 4'd5;
	localparam logic [3:0] STEP_BYTE_LAST  = 4'd8;

	localparam logic [3:0] NIB_WAKE = 4'h3;
	localparam logic [3:0] NIB_MODE = 4'h2;

	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h28;
			2'd1:    b = 8'h0C;
			2'd2:    b = 8'h01;
			default: b = 8'h06;
		endcase
		return b;
	endfunction

	// zero acts as one, wide values saturate to the counter range
	function automatic logic [CNT_W-1:0] load_count(input logic [CFG_W-1:0] v);
		logic [CFG_W+CNT_W-1:0] ext;
		logic [CFG_W+CNT_W-1:0] lim;
		logic [CNT_W-1:0]       c;
		ext = {{CNT_W{1'b0}}, v};
		lim = {{CFG_W{1'b0}}, {CNT_W{1'b1}}};
		if (ext > lim) begin
			c = '1;
		end else if (v == '0) begin
			c = CNT_W'(1);
		end else begin
			c = ext[CNT_W-1:0];
		end
		return c;
	endfunction

endpackage

>>> src/char_lcd_nibble_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Timed sequencer that drives a character display over a 4-bit data bus.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the item kind (tick, send byte, start init),
// s_tdata the byte and its register-select bit. Every accepted item yields
// exactly one result on the output stream: the pin levels (rs, enable,
// D7..D4) after the item, a busy flag and a reject flag. Time moves only on
// tick items; a send or init that arrives while a sequence runs is dropped
// and flagged as rejected.
// The result of a transaction is registered and is on m_tdata in the cycle
// after it is accepted. One item per cycle while m_tready does not stall;
// one pass through the sequencer logic updates state and result registers.
// The single result register parts the two sides: s_tready stays high while
// the result register is empty or being taken, and drops only while a
// result waits under a stall on m_tready.
// Reset: sequencer idle, all pins low, result register empty, timing
// registers at their defaults. Timing registers are written over the APB
// port at byte address 4*index and should only change while idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lcdn_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,  // [7:0] data_byte, [8] select_data
	input  logic [1:0]                 s_tuser,  // [1:0] cmd
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata   // [0] rs_pin, [1] enable_pin,
	                                             // [5:2] bus_nibble, [6] busy_res,
	                                             // [7] rejected
);
	import lcdn_pkg::*;

	logic [CFG_W-1:0] cfg_q [NUM_CFG];
	logic [2:0]       widx;
	logic             wr_en;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       held_byte_q, held_byte_d;
	logic             held_sel_q, held_sel_d;
	logic [3:0]       step_q, step_d;
	logic             rs_q, rs_d, en_q, en_d;
	logic [3:0]       nib_q, nib_d;

	logic             acc;
	logic             rej;
	logic             byte_go, step_go;
	logic [7:0]       byte_val;
	logic             byte_sel;
	logic [3:0]       step_n;
	logic [CFG_W-1:0] gap;
	logic [7:0]       res_d;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign widx   = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_POWER_UP]  <= CFG_W'(20000);
			cfg_q[REG_EN_HIGH]   <= CFG_W'(4000);
			cfg_q[REG_WAKE_GAP1] <= CFG_W'(5000);
			cfg_q[REG_WAKE_GAP2] <= CFG_W'(150);
			cfg_q[REG_MODE_GAP]  <= CFG_W'(1000);
			cfg_q[REG_CMD_SETL]  <= CFG_W'(2000);
			cfg_q[REG_DATA_SETL] <= CFG_W'(40);
		end else if (wr_en && (widx < 3'(NUM_CFG))) begin
			cfg_q[widx] <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (widx < 3'(NUM_CFG)) begin
			prdata = 32'(cfg_q[widx]);
		end
	end

	// ---------------- handshake ----------------
	assign s_tready = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	// gap after an init nibble; the third wake nibble has none
	always_comb begin
		case (step_q)
			STEP_WAKE1:    gap = cfg_q[REG_WAKE_GAP1];
			STEP_WAKE2:    gap = cfg_q[REG_WAKE_GAP2];
			STEP_MODE_NIB: gap = cfg_q[REG_MODE_GAP];
			default:       gap = '0;
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		held_byte_d = held_byte_q;
		held_sel_d  = held_sel_q;
		step_d      = step_q;
		rs_d        = rs_q;
		en_d        = en_q;
		nib_d       = nib_q;
		rej         = 1'b0;
		byte_go     = 1'b0;
		byte_val    = s_tdata[7:0];
		byte_sel    = s_tdata[8];
		step_go     = 1'b0;
		step_n      = step_q + 4'd1;

		if (acc) begin
			if (s_tuser == CMD_SEND || s_tuser == CMD_INIT) begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else if (s_tuser == CMD_SEND) begin
					step_d  = STEP_NONE;
					byte_go = 1'b1;
				end else begin
					step_d  = STEP_NONE;
					rs_d    = 1'b0;
					en_d    = 1'b0;
					nib_d   = '0;
					phase_d = PH_POWER;
					cnt_d   = load_count(cfg_q[REG_POWER_UP]);
				end
			end else if (phase_q != PH_IDLE) begin
				if (cnt_q > CNT_W'(1)) begin
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					case (phase_q)
						PH_POWER: begin
							step_go = 1'b1;
							step_n  = STEP_WAKE1;
						end
						PH_HI_STROBE: begin
							en_d    = 1'b0;
							phase_d = PH_HI_HOLD;
							cnt_d   = CNT_W'(1);
						end
						PH_HI_HOLD: begin
							rs_d    = held_sel_q;
							en_d    = 1'b1;
							nib_d   = held_byte_q[3:0];
							phase_d = PH_LO_STROBE;
							cnt_d   = load_count(cfg_q[REG_EN_HIGH]);
						end
						PH_LO_STROBE: begin
							en_d    = 1'b0;
							phase_d = PH_SETTLE;
							cnt_d   = load_count(held_sel_q ? cfg_q[REG_DATA_SETL]
								: cfg_q[REG_CMD_SETL]);
						end
						PH_SETTLE: begin
							if (step_q != STEP_NONE) begin
								step_go = 1'b1;
							end else begin
								phase_d = PH_IDLE;
								cnt_d   = '0;
							end
						end
						PH_NIB_STROBE: begin
							en_d    = 1'b0;
							phase_d = PH_NIB_GAP;
							cnt_d   = load_count(gap);
						end
						PH_NIB_GAP: begin
							step_go = 1'b1;
						end
						default: begin
							phase_d = PH_IDLE;
							cnt_d   = '0;
							step_d  = STEP_NONE;
						end
					endcase
				end
			end
		end

		// advance the init sequence
		if (step_go) begin
			step_d = step_n;
			if (step_n >= STEP_WAKE1 && step_n <= STEP_MODE_NIB) begin
				rs_d    = 1'b0;
				en_d    = 1'b1;
				nib_d   = (step_n == STEP_MODE_NIB) ? NIB_MODE : NIB_WAKE;
				phase_d = PH_NIB_STROBE;
				cnt_d   = load_count(cfg_q[REG_EN_HIGH]);
			end else if (step_n >= STEP_BYTE_FIRST && step_n <= STEP_BYTE_LAST) begin
				byte_go  = 1'b1;
				byte_val = init_byte(2'(step_n - STEP_BYTE_FIRST));
				byte_sel = 1'b0;
			end else begin
				step_d  = STEP_NONE;
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		end

		// latch a byte and put out its high nibble
		if (byte_go) begin
			held_byte_d = byte_val;
			held_sel_d  = byte_sel;
			rs_d        = byte_sel;
			en_d        = 1'b1;
			nib_d       = byte_val[7:4];
			phase_d     = PH_HI_STROBE;
			cnt_d       = load_count(cfg_q[REG_EN_HIGH]);
		end
	end

	// ---------------- result ----------------
	always_comb begin
		res_d = {rej, (phase_d != PH_IDLE), nib_d, en_d, rs_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			held_byte_q <= '0;
			held_sel_q  <= 1'b0;
			step_q      <= STEP_NONE;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			nib_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			held_byte_q <= held_byte_d;
			held_sel_q  <= held_sel_d;
			step_q      <= step_d;
			rs_q        <= rs_d;
			en_q        <= en_d;
			nib_q       <= nib_d;
			if (acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata_q <= res_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------- assertions ----------------
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[6])
		else $error("rejected transaction reported while idle");

	a_en_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[6])
		else $error("enable high while sequencer idle");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> cnt_q != '0)
		else $error("timed phase with zero count");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction produced no result");

endmodule
